// ===== design/c8ic_pkg.sv =====
// c8ic_pkg: shared types and constants for the chip8 instruction core
// no dependencies
package c8ic_pkg;

    localparam int MEM_BYTES_DEF = 4096;
    localparam int SCREEN_COLUMNS_DEF = 64;
    localparam int SCREEN_ROWS_DEF = 32;
    localparam int DISP_BYTES = 256;

    localparam logic [11:0] START_PC = 12'h200;
    localparam logic [11:0] FONT_BASE = 12'h050;
    localparam logic [6:0] FONT_LEN = 7'd80;
    localparam logic [15:0] INS_CLS = 16'h00E0;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_STEP  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        GRP_SYS  = 4'h0,
        GRP_JMP  = 4'h1,
        GRP_LD   = 4'h6,
        GRP_ADD  = 4'h7,
        GRP_LDI  = 4'hA,
        GRP_DRW  = 4'hD
    } grp_t;

    function automatic logic [7:0] font_byte(input logic [6:0] i);
        logic [7:0] f [0:79];
        f = '{8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
              8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
              8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
              8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
              8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
              8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
              8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
              8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80};
        return f[i];
    endfunction

endpackage

// ===== design/c8ic_ram.sv =====
// c8ic_ram: generic single-port ram with registered read
// depends on nothing
module c8ic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== design/chip8_instruction_core.sv =====
// chip8_instruction_core: chip-8 subset with program memory and packed display
// depends on c8ic_pkg and c8ic_ram
//
// one input beat gives exactly one output beat
//   s_axis_tdata: opcode[1:0], address[13:2], data[21:14], zero fill to 24 bits
//   m_axis_tdata: read_data[7:0], instruction[23:8], next_pc[35:24],
//                 collision[36], zero fill to 40 bits
// program memory (MEMORY_BYTES x 8) and display (256 bytes of 8 pixels) are
// single-port rams with registered read; the sixteen V registers are flops
// a write or none goes straight to output, a read waits for the display byte, a
// step fetches both instruction bytes and executes, a draw reads each sprite row
// and rewrites two display bytes, clear screen zeroes all 256; one item at a time
// after reset a pass over all MEMORY_BYTES addresses zeroes memory, loads the
// font at 0x050 and zeroes the display; s_axis_tready stays low meanwhile
// a result waits in the output register while m_axis_tready is low; the next
// input beat is still taken and its result waits until that register is free
module chip8_instruction_core
    import c8ic_pkg::*;
#(
    parameter int MEMORY_BYTES = MEM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // opcode, address, data
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // read_data, instruction, next_pc, collision
);
    localparam int AW = $clog2(MEMORY_BYTES);

    typedef enum logic [12:0] {
        S_INIT  = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_FHI   = 13'b0000000000100,
        S_FLO   = 13'b0000000001000,
        S_EXEC  = 13'b0000000010000,
        S_CLS   = 13'b0000000100000,
        S_DROW  = 13'b0000001000000,
        S_DB0   = 13'b0000010000000,
        S_DB1   = 13'b0000100000000,
        S_DMOD  = 13'b0001000000000,
        S_RDW   = 13'b0010000000000,
        S_OUT   = 13'b0100000000000,
        S_DWAIT = 13'b1000000000000
    } state_t;

    // 12-bit address folded into the memory size by compare and subtract
    function automatic logic [AW-1:0] mem_wrap(input logic [11:0] a);
        logic [12:0] t;
        t = {1'b0, a};
        for (int k = 0; k < 3; k++)
        begin
            if (t >= 13'(MEMORY_BYTES))
            begin
                t = t - 13'(MEMORY_BYTES);
            end
        end
        return AW'(t);
    endfunction

    state_t state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [11:0] pc_reg, pc_next, i_reg, i_next;
    logic [7:0] v_reg [0:15];
    logic [7:0] v_next [0:15];
    logic [15:0] ins_reg, ins_next;
    logic [7:0] rd_reg, rd_next;
    logic [1:0] op_reg, op_next;
    logic [7:0] line_reg, line_next;
    logic [3:0] row_reg, row_next;
    logic [5:0] x0_reg, x0_next;
    logic [4:0] y0_reg, y0_next;
    logic       out_v_reg, out_v_next;
    logic [39:0] out_reg, out_next;

    logic          m_we, d_we;
    logic [AW-1:0] m_addr;
    logic [7:0]    m_wdata, m_rdata, d_wdata, d_rdata;
    logic [7:0]    d_addr;

    c8ic_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
        .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata));
    c8ic_ram #(.WIDTH(8), .DEPTH(DISP_BYTES)) u_disp (
        .clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata));

    logic [1:0]  in_op;
    logic [11:0] in_addr;
    logic [7:0]  in_data;
    assign in_op = s_axis_tdata[1:0];
    assign in_addr = s_axis_tdata[13:2];
    assign in_data = s_axis_tdata[21:14];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata = out_reg;

    // sprite row shifted into pixel position, spans two display bytes
    logic [5:0]  yrow;
    logic [15:0] span;
    logic [11:0] ptr;
    logic [11:0] cnt12;
    logic [6:0]  font_off;
    always_comb
    begin
        yrow = {1'b0, y0_reg} + {2'b0, row_reg};
        span = {line_reg, 8'h00} >> x0_reg[2:0];
        ptr = i_reg + {8'h0, row_reg};
        cnt12 = 12'(cnt_reg);
        font_off = 7'(cnt12 - FONT_BASE);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        pc_next = pc_reg;
        i_next = i_reg;
        for (int k = 0; k < 16; k++)
        begin
            v_next[k] = v_reg[k];
        end
        ins_next = ins_reg;
        rd_next = rd_reg;
        op_next = op_reg;
        line_next = line_reg;
        row_next = row_reg;
        x0_next = x0_reg;
        y0_next = y0_reg;
        out_v_next = out_v_reg;
        out_next = out_reg;
        m_we = 1'b0;
        m_addr = mem_wrap(pc_reg);
        m_wdata = 8'h00;
        d_we = 1'b0;
        d_addr = cnt_reg[7:0];
        d_wdata = 8'h00;

        if (out_v_reg && m_axis_tready)
        begin
            out_v_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                m_we = 1'b1;
                m_addr = cnt_reg;
                m_wdata = (cnt12 >= FONT_BASE && cnt12 < FONT_BASE + 12'(FONT_LEN))
                          ? font_byte(font_off) : 8'h00;
                d_we = (cnt12 < 12'(DISP_BYTES));
                d_addr = cnt_reg[7:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AW'(MEMORY_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    op_next = in_op;
                    rd_next = 8'h00;
                    ins_next = 16'h0000;
                    unique case (op_t'(in_op))
                        OP_WRITE:
                        begin
                            m_we = 1'b1;
                            m_addr = mem_wrap(in_addr);
                            m_wdata = in_data;
                            state_next = S_OUT;
                        end
                        OP_STEP:
                        begin
                            m_addr = mem_wrap(pc_reg);
                            state_next = S_FHI;
                        end
                        OP_READ:
                        begin
                            d_addr = in_addr[7:0];
                            state_next = S_RDW;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_RDW:
            begin
                rd_next = d_rdata;
                state_next = S_OUT;
            end
            S_FHI:
            begin
                m_addr = mem_wrap(pc_reg + 12'd1);
                ins_next[15:8] = m_rdata;
                state_next = S_FLO;
            end
            S_FLO:
            begin
                ins_next[7:0] = m_rdata;
                pc_next = pc_reg + 12'd2;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_OUT;
                case (ins_reg[15:12])
                    GRP_SYS:
                    begin
                        if (ins_reg == INS_CLS)
                        begin
                            cnt_next = '0;
                            state_next = S_CLS;
                        end
                    end
                    GRP_JMP: pc_next = ins_reg[11:0];
                    GRP_LD: v_next[ins_reg[11:8]] = ins_reg[7:0];
                    GRP_ADD: v_next[ins_reg[11:8]] = v_reg[ins_reg[11:8]] + ins_reg[7:0];
                    GRP_LDI: i_next = ins_reg[11:0];
                    GRP_DRW:
                    begin
                        x0_next = v_reg[ins_reg[11:8]][5:0];
                        y0_next = v_reg[ins_reg[7:4]][4:0];
                        v_next[15] = 8'h00;
                        row_next = 4'd0;
                        state_next = S_DROW;
                    end
                    default: ;
                endcase
            end
            S_CLS:
            begin
                d_we = 1'b1;
                d_addr = cnt_reg[7:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[7:0] == 8'hFF)
                begin
                    state_next = S_OUT;
                end
            end
            S_DROW:
            begin
                // issue the sprite row read
                if (row_reg == ins_reg[3:0])
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    m_addr = mem_wrap(ptr);
                    state_next = S_DWAIT;
                end
            end
            S_DWAIT:
            begin
                line_next = m_rdata;
                d_addr = {yrow[4:0], x0_reg[5:3]};
                state_next = S_DB0;
            end
            S_DB0:
            begin
                // first display byte arrives, write it back xored
                d_we = 1'b1;
                d_addr = {yrow[4:0], x0_reg[5:3]};
                d_wdata = d_rdata ^ span[15:8];
                if ((d_rdata & span[15:8]) != 8'h00)
                begin
                    v_next[15] = 8'h01;
                end
                state_next = S_DB1;
            end
            S_DB1:
            begin
                d_addr = {yrow[4:0], x0_reg[5:3] + 3'd1};
                state_next = S_DMOD;
            end
            S_DMOD:
            begin
                d_we = 1'b1;
                d_addr = {yrow[4:0], x0_reg[5:3] + 3'd1};
                d_wdata = d_rdata ^ span[7:0];
                if ((d_rdata & span[7:0]) != 8'h00)
                begin
                    v_next[15] = 8'h01;
                end
                row_next = row_reg + 4'd1;
                state_next = S_DROW;
            end
            S_OUT:
            begin
                if (!out_v_reg || m_axis_tready)
                begin
                    out_v_next = 1'b1;
                    out_next = {3'b000, v_next[15][0], pc_next, ins_reg, rd_reg};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg <= '0;
            pc_reg <= START_PC;
            i_reg <= 12'h000;
            for (int k = 0; k < 16; k++)
            begin
                v_reg[k] <= 8'h00;
            end
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            pc_reg <= pc_next;
            i_reg <= i_next;
            for (int k = 0; k < 16; k++)
            begin
                v_reg[k] <= v_next[k];
            end
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_reg <= ins_next;
        rd_reg <= rd_next;
        op_reg <= op_next;
        line_reg <= line_next;
        row_reg <= row_next;
        x0_reg <= x0_next;
        y0_reg <= y0_next;
        out_reg <= out_next;
    end

    // read and write items never carry an instruction word
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) && op_reg != OP_STEP |-> out_reg[23:8] == 16'h0000)
        else $error("non-step result with instruction");
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == S_IDLE)
        else $error("ready while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> $past(state_reg) == S_OUT)
        else $error("result outside output state");
endmodule

// ===== dv/chip8_instruction_core_test.sv =====
// chip8_instruction_core_test: self-checking stream testbench for the chip-8 core
// depends on c8ic_pkg and chip8_instruction_core
`timescale 1ns / 1ps

module chip8_instruction_core_test;
    import c8ic_pkg::*;

    localparam int MEM_SIZE = MEM_BYTES_DEF;
    localparam int COLS = SCREEN_COLUMNS_DEF;
    localparam int ROWS = SCREEN_ROWS_DEF;
    localparam int PIX = COLS * ROWS;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [7:0]  data;
        logic [11:0] address;
        op_t         opcode;
    } cmd_t;

    typedef struct packed {
        logic        collision;
        logic [11:0] next_pc;
        logic [15:0] instruction;
        logic [7:0]  read_data;
    } res_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    chip8_instruction_core i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // shadow machine state
    logic [7:0]  mem_sh [MEM_SIZE];
    logic        pix_sh [PIX];
    logic [7:0]  vreg [16];
    logic [11:0] pc_sh;
    logic [11:0] idx_sh;

    cmd_t pending_cmds[$];
    res_t expected_results[$];
    int   errors = 0;
    bit   stim_done = 0;
    longint cycles = 0;
    int   hold_off = 0;
    bit   hold_req = 0;
    bit   hold_done = 0;

    function automatic void machine_reset();
        for (int i = 0; i < MEM_SIZE; i++)
            mem_sh[i] = 8'h00;
        for (int i = 0; i < 80; i++)
            mem_sh[FONT_BASE + i] = font_byte(i[6:0]);
        for (int i = 0; i < PIX; i++)
            pix_sh[i] = 1'b0;
        for (int i = 0; i < 16; i++)
            vreg[i] = 8'h00;
        pc_sh = START_PC;
        idx_sh = 12'h000;
    endfunction

    function automatic void draw_sprite(int vx, int vy, int n);
        int x0;
        int y0;
        logic [7:0] line;
        int p;
        x0 = vreg[vx];
        y0 = vreg[vy];
        vreg[15] = 8'h00;
        for (int r = 0; r < n; r++)
        begin
            line = mem_sh[(idx_sh + r) % 4096 % MEM_SIZE];
            for (int b = 0; b < 8; b++)
            begin
                if (line[7 - b])
                begin
                    p = ((x0 + b) % COLS) + ((y0 + r) % ROWS) * COLS;
                    if (pix_sh[p])
                    begin
                        pix_sh[p] = 1'b0;
                        vreg[15] = 8'h01;
                    end
                    else
                        pix_sh[p] = 1'b1;
                end
            end
        end
    endfunction

    function automatic res_t core_result(cmd_t c);
        res_t r;
        logic [15:0] ins;
        int base;
        r = '0;
        case (c.opcode)
            OP_WRITE: mem_sh[c.address % MEM_SIZE] = c.data;
            OP_STEP:
            begin
                ins = {mem_sh[pc_sh % MEM_SIZE], mem_sh[12'(pc_sh + 1) % MEM_SIZE]};
                pc_sh = pc_sh + 12'd2;
                case (ins[15:12])
                    GRP_SYS:
                        if (ins == INS_CLS)
                            for (int i = 0; i < PIX; i++)
                                pix_sh[i] = 1'b0;
                    GRP_JMP: pc_sh = ins[11:0];
                    GRP_LD:  vreg[ins[11:8]] = ins[7:0];
                    GRP_ADD: vreg[ins[11:8]] = vreg[ins[11:8]] + ins[7:0];
                    GRP_LDI: idx_sh = ins[11:0];
                    GRP_DRW: draw_sprite(ins[11:8], ins[7:4], ins[3:0]);
                    default: ;
                endcase
                r.instruction = ins;
            end
            OP_READ:
            begin
                base = c.address[7:0] * 8;
                for (int b = 0; b < 8; b++)
                    r.read_data[7 - b] = pix_sh[base + b];
            end
            default: ;
        endcase
        r.next_pc = pc_sh;
        r.collision = vreg[15][0];
        return r;
    endfunction

    function automatic void push_cmd(op_t op, int a, int d);
        cmd_t c;
        c.opcode = op;
        c.address = a[11:0];
        c.data = d[7:0];
        pending_cmds.push_back(c);
    endfunction

    // write a two-byte instruction at the given address
    function automatic void load_ins(int a, logic [15:0] ins);
        push_cmd(OP_WRITE, a, ins[15:8]);
        push_cmd(OP_WRITE, (a + 1) % 4096, ins[7:0]);
    endfunction

    always #5 clk = ~clk;

    always @(posedge clk)
        cycles <= cycles + 1;

    // long receiver stall, counted here once requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_off <= 400;
            hold_done <= 1'b1;
        end
        else if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // driver
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            send_gap <= 0;
        end
        else if (s_axis_tvalid && !s_axis_tready)
            ;
        else
        begin
            if (s_axis_tvalid)
                expected_results.push_back(core_result(cmd_t'(s_axis_tdata[21:0])));
            if (send_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_cmds.size() > 0)
            begin
                s_axis_tdata <= {2'b00, pending_cmds.pop_front()};
                s_axis_tvalid <= 1'b1;
                send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor
    int recv_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = res_t'(m_axis_tdata[36:0]);
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: %h", got);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.read_data !== want.read_data)
                    begin
                        $error("read_data exp %h got %h", want.read_data, got.read_data);
                        errors++;
                    end
                    if (got.instruction !== want.instruction)
                    begin
                        $error("instruction exp %h got %h", want.instruction,
                               got.instruction);
                        errors++;
                    end
                    if (got.next_pc !== want.next_pc)
                    begin
                        $error("next_pc exp %h got %h", want.next_pc, got.next_pc);
                        errors++;
                    end
                    if (got.collision !== want.collision)
                    begin
                        $error("collision exp %b got %b", want.collision, got.collision);
                        errors++;
                    end
                end
            end
            if (hold_off > 0)
                m_axis_tready <= 1'b0;
            else if (recv_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                recv_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // random program: mostly valid instructions built around draws
    function automatic logic [15:0] rand_ins();
        logic [3:0] x;
        logic [3:0] y;
        x = $urandom_range(0, 15);
        y = $urandom_range(0, 15);
        case ($urandom_range(0, 11))
            0:  return ($urandom_range(0, 3) == 0) ? INS_CLS : 16'($urandom_range(0, 16'h0FFF));
            1, 2: return {GRP_LD, x, 8'($urandom)};
            3, 4: return {GRP_ADD, x, 8'($urandom)};
            5:  return {GRP_LDI, 12'($urandom)};
            6, 7, 8: return {GRP_DRW, x, y, 4'($urandom)};
            9:  return 16'($urandom);
            default: return {GRP_LDI, FONT_BASE + 12'($urandom_range(0, 15) * 5)};
        endcase
    endfunction

    initial
    begin
        int n;
        machine_reset();
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, font draw, wrap, vf as coordinate, zero-row draw
        push_cmd(OP_READ, 0, 0);
        push_cmd(OP_READ, 12'hFFF, 8'hFF);
        push_cmd(OP_NONE, 12'hFFF, 8'hFF);
        load_ins(12'h200, {GRP_LD, 4'hF, 8'hFF});
        load_ins(12'h202, {GRP_ADD, 4'hF, 8'h02});
        load_ins(12'h204, {GRP_LDI, 12'h050});
        load_ins(12'h206, {GRP_DRW, 4'hF, 4'hF, 4'h5});
        load_ins(12'h208, {GRP_DRW, 4'hF, 4'hF, 4'h5});
        load_ins(12'h20A, {GRP_DRW, 4'h0, 4'h0, 4'h0});
        load_ins(12'h20C, {GRP_JMP, 12'hFFE});
        load_ins(12'hFFE, {GRP_LD, 4'h3, 8'h3F});
        for (int i = 0; i < 9; i++)
            push_cmd(OP_STEP, 0, 0);
        push_cmd(OP_READ, 0, 0);
        push_cmd(OP_READ, 12'h0FF, 0);
        push_cmd(OP_STEP, 0, 0);

        // random: program fragments then execute, with reads and noise
        n = 0;
        while (n < 1000)
        begin
            int len;
            int base;
            base = $urandom_range(12'h200, 12'hF00) & 12'hFFE;
            len = $urandom_range(2, 10);
            load_ins(base, {GRP_JMP, 12'(base + 2)});
            n += 2;
            for (int k = 0; k < len; k++)
            begin
                load_ins(base + 2 + 2 * k, rand_ins());
                n += 2;
            end
            // random write to any memory address as noise
            push_cmd(OP_WRITE, $urandom_range(0, 4095), $urandom);
            for (int k = 0; k < len + 1; k++)
            begin
                push_cmd(OP_STEP, 0, 0);
                if ($urandom_range(0, 3) == 0)
                    push_cmd(OP_READ, $urandom_range(0, 4095), $urandom);
            end
            n += 2 * len;
            if ($urandom_range(0, 19) == 0)
                push_cmd(OP_NONE, $urandom_range(0, 4095), $urandom);
            if ($urandom_range(0, 9) == 0)
                push_cmd(OP_STEP, 0, 0);
        end
        // steps execute at current pc, not necessarily the fragment: that is fine,
        // predictor follows whatever pc holds

        wait (pending_cmds.size() < 600);
        hold_req = 1'b1;
        wait (pending_cmds.size() == 0 && !s_axis_tvalid);
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done && expected_results.size() == 0);
        repeat (400) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("chip8_instruction_core: match");
        else
            $display("chip8_instruction_core: mismatch");
        $finish;
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("chip8_instruction_core: mismatch");
        $finish;
    end

endmodule

// ===== chip8_instruction_core.f =====
design/c8ic_pkg.sv
design/c8ic_ram.sv
design/chip8_instruction_core.sv
dv/chip8_instruction_core_test.sv
